// ----- rtl/sbusfd_pkg.sv -----
package sbusfd_pkg;

   // Frame geometry.
   localparam int FRAME_BYTES   = 25;
   localparam int CHANNEL_COUNT = 16;
   localparam int CHANNEL_BITS  = 11;
   localparam int CH_IDX_W      = $clog2(CHANNEL_COUNT);
   localparam int POS_W         = 5;
   localparam int ACC_W         = CHANNEL_BITS - 1;
   localparam int ACC_CNT_W     = 4;

   // Byte positions inside a frame.
   localparam logic [POS_W-1:0] POS_IDLE      = '0;
   localparam logic [POS_W-1:0] POS_FIRST     = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LAST_DATA = POS_W'(FRAME_BYTES - 3);
   localparam logic [POS_W-1:0] POS_FLAG      = POS_W'(FRAME_BYTES - 2);

   // Result error codes.
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_HEADER = 2'd1;
   localparam logic [1:0] ERR_FOOTER = 2'd2;
   localparam logic [1:0] ERR_SHORT  = 2'd3;

   // Control register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_VALUE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOOTER_NORMAL   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOOTER_LOST     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOOTER_FAILSAFE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_CENTER  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_FULL    = 3'd5;

   localparam logic [7:0]              RST_HEADER_VALUE    = 8'h0F;
   localparam logic [7:0]              RST_FOOTER_NORMAL   = 8'h00;
   localparam logic [7:0]              RST_FOOTER_LOST     = 8'h04;
   localparam logic [7:0]              RST_FOOTER_FAILSAFE = 8'h08;
   localparam logic [CHANNEL_BITS-1:0] RST_CHANNEL_CENTER  = 11'd1024;
   localparam logic [CHANNEL_BITS-1:0] RST_CHANNEL_FULL    = 11'd1695;

   // Divider geometry: dividend is 2*|num|*4096 + |den|, divisor is 2*|den|.
   localparam int DIVIDEND_W = CHANNEL_BITS + 14;
   localparam int DIVISOR_W  = CHANNEL_BITS + 1;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

   typedef struct packed {
      logic [7:0]              header_value;
      logic [7:0]              footer_normal;
      logic [7:0]              footer_lost;
      logic [7:0]              footer_failsafe;
      logic [CHANNEL_BITS-1:0] channel_center;
      logic [CHANNEL_BITS-1:0] channel_full;
   } csr_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] error_code;
      logic       digital_one;
      logic       digital_two;
      logic       lost_flag;
      logic       failsafe_flag;
   } frame_event_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- rtl/sbusfd_unpack.sv -----
module sbusfd_unpack import sbusfd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  csr_type                 csr,
   input  logic                    byte_fire,
   input  logic [7:0]              data_byte,
   input  logic                    frame_start,
   input  logic [CH_IDX_W-1:0]     rd_index,
   output logic [CHANNEL_BITS-1:0] rd_data,
   output frame_event_type         frame_event
);

   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [ACC_CNT_W-1:0] bits_ff, bits_in;
   logic [CH_IDX_W-1:0]  ch_ff, ch_in;
   logic [7:0]           flag_ff, flag_in;
   logic                 hdr_good_ff, hdr_good_in;

   logic [CHANNEL_BITS-1:0] store [CHANNEL_COUNT];
   logic                    store_we;
   logic [CHANNEL_BITS-1:0] rd_data_ff;

   logic [ACC_W+7:0]     merged;
   logic [ACC_CNT_W:0]   bits_sum;
   logic                 have_channel;
   logic                 match_normal, match_lost, match_failsafe;

   assign merged       = {8'b0, acc_ff} | ({(ACC_W)'(0), data_byte} << bits_ff);
   assign bits_sum     = {1'b0, bits_ff} + (ACC_CNT_W+1)'(8);
   assign have_channel = bits_sum >= (ACC_CNT_W+1)'(CHANNEL_BITS);

   assign match_normal   = data_byte == csr.footer_normal;
   assign match_lost     = data_byte == csr.footer_lost;
   assign match_failsafe = data_byte == csr.footer_failsafe;

   always_comb begin
      pos_in      = pos_ff;
      acc_in      = acc_ff;
      bits_in     = bits_ff;
      ch_in       = ch_ff;
      flag_in     = flag_ff;
      hdr_good_in = hdr_good_ff;
      store_we    = 1'b0;
      frame_event = '0;
      if (byte_fire) begin
         if (frame_start) begin
            if (pos_ff != POS_IDLE) begin
               frame_event.valid      = 1'b1;
               frame_event.error_code = ERR_SHORT;
               frame_event.lost_flag  = 1'b1;
            end
            hdr_good_in = data_byte == csr.header_value;
            acc_in      = '0;
            bits_in     = '0;
            ch_in       = '0;
            flag_in     = '0;
            pos_in      = POS_FIRST;
         end else if (pos_ff == POS_IDLE) begin
            pos_in = POS_IDLE;
         end else if (pos_ff <= POS_LAST_DATA) begin
            // At most one channel completes per byte since fewer than 11 bits wait.
            if (have_channel) begin
               store_we = 1'b1;
               acc_in   = ACC_W'(merged[ACC_W+7:CHANNEL_BITS]);
               bits_in  = ACC_CNT_W'(bits_sum - (ACC_CNT_W+1)'(CHANNEL_BITS));
               ch_in    = ch_ff + CH_IDX_W'(1);
            end else begin
               acc_in  = merged[ACC_W-1:0];
               bits_in = bits_sum[ACC_CNT_W-1:0];
            end
            pos_in = pos_ff + POS_W'(1);
         end else if (pos_ff == POS_FLAG) begin
            flag_in = data_byte;
            pos_in  = pos_ff + POS_W'(1);
         end else begin
            pos_in            = POS_IDLE;
            frame_event.valid = 1'b1;
            if (!hdr_good_ff) begin
               frame_event.error_code = ERR_HEADER;
               frame_event.lost_flag  = 1'b1;
            end else if (!match_normal && !match_lost && !match_failsafe) begin
               frame_event.error_code = ERR_FOOTER;
               frame_event.lost_flag  = 1'b1;
            end else begin
               frame_event.error_code    = ERR_NONE;
               frame_event.digital_one   = flag_ff[0];
               frame_event.digital_two   = flag_ff[1];
               frame_event.lost_flag     = flag_ff[2] | match_lost;
               frame_event.failsafe_flag = flag_ff[3] | (!match_lost & match_failsafe);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= POS_IDLE;
         acc_ff      <= '0;
         bits_ff     <= '0;
         ch_ff       <= '0;
         flag_ff     <= '0;
         hdr_good_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         acc_ff      <= acc_in;
         bits_ff     <= bits_in;
         ch_ff       <= ch_in;
         flag_ff     <= flag_in;
         hdr_good_ff <= hdr_good_in;
      end
   end

   // Registered read: the data for an address shows up in the next cycle.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store[ch_ff] <= merged[CHANNEL_BITS-1:0];
      end
      rd_data_ff <= store[rd_index];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sbusfd_divider.sv -----
module sbusfd_divider import sbusfd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output div_status_type        status,
   output logic [DIVIDEND_W-1:0] quotient
);

   // Restoring division, one quotient bit per cycle; quotient bits shift in
   // behind the dividend bits as they are consumed.
   logic [DIVIDEND_W-1:0] q_ff, q_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W+1:0]  diff;

   assign shifted = {rem_ff, q_ff[DIVIDEND_W-1]};
   assign diff    = {1'b0, shifted} - {2'b0, dsr_ff};

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         q_in    = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = DIV_CNT_W'(DIVIDEND_W - 1);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (!diff[DIVISOR_W+1]) begin
            rem_in = diff[DIVISOR_W-1:0];
            q_in   = {q_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_W-1:0];
            q_in   = {q_ff[DIVIDEND_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - DIV_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = q_ff;

endmodule

// ----- rtl/sbus_frame_decoder.sv -----
// Channel  Direction  Handshake                  Payload
// req_     in         req_valid / req_stall      data_byte, frame_start
// rsp_     out        rsp_valid / rsp_stall      channel_index .. last (one port each)
// csr_     in         csr_we (no wait)           csr_index, csr_wdata
//
// A byte is taken while the sequencer is idle and the result register can move on.
// A good footer starts sixteen normalizations on one shared restoring divider that
// yields one quotient bit per cycle, and the result side can stall each result.
// The input is stalled meanwhile. Reset is synchronous and active high; it restores
// the control registers to their defaults and leaves the decoder waiting for
// a frame start.
module sbus_frame_decoder import sbusfd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_frame_start,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [CH_IDX_W-1:0]     rsp_channel_index,
   output logic [CHANNEL_BITS-1:0] rsp_raw_value,
   output logic signed [15:0]      rsp_normalized,
   output logic                    rsp_digital_one,
   output logic                    rsp_digital_two,
   output logic                    rsp_lost_flag,
   output logic                    rsp_failsafe_flag,
   output logic [1:0]              rsp_error_code,
   output logic                    rsp_last,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CHANNEL_BITS-1:0] csr_wdata
);

   // Sequencer states for the per-channel normalization pass.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_START = 2'd1;
   localparam logic [1:0] S_DIV   = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   csr_type csr_ff;

   logic [1:0]          state_ff, state_in;
   logic [CH_IDX_W-1:0] ch_ff, ch_in;

   // Frame flags captured from a good footer, shared by all sixteen results.
   logic d1_ff, d1_in, d2_ff, d2_in, lost_ff, lost_in, fs_ff, fs_in;

   // Per-channel operand details kept while the divider runs.
   logic [CHANNEL_BITS-1:0] raw_ff, raw_in;
   logic                    neg_ff, neg_in;
   logic                    num_neg_ff, num_neg_in;
   logic                    num_zero_ff, num_zero_in;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CH_IDX_W-1:0]     o_idx_ff, o_idx_in;
   logic [CHANNEL_BITS-1:0] o_raw_ff, o_raw_in;
   logic [15:0]             o_norm_ff, o_norm_in;
   logic                    o_d1_ff, o_d1_in, o_d2_ff, o_d2_in;
   logic                    o_lost_ff, o_lost_in, o_fs_ff, o_fs_in;
   logic [1:0]              o_err_ff, o_err_in;
   logic                    o_last_ff, o_last_in;

   logic                    byte_fire;
   logic                    out_free;
   frame_event_type         frame_event;
   logic [CHANNEL_BITS-1:0] store_data;

   logic signed [CHANNEL_BITS:0] numer;
   logic signed [CHANNEL_BITS:0] denom;
   logic [CHANNEL_BITS-1:0]      abs_num;
   logic [CHANNEL_BITS-1:0]      abs_den;
   logic [DIVIDEND_W-1:0]        dividend;
   logic [DIVISOR_W-1:0]         divisor;
   logic                         div_start;
   div_status_type               div_status;
   logic [DIVIDEND_W-1:0]        quotient;
   logic [15:0]                  norm_value;

   // The input waits while the sequencer works or a result cannot move on.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign byte_fire = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.header_value    <= RST_HEADER_VALUE;
         csr_ff.footer_normal   <= RST_FOOTER_NORMAL;
         csr_ff.footer_lost     <= RST_FOOTER_LOST;
         csr_ff.footer_failsafe <= RST_FOOTER_FAILSAFE;
         csr_ff.channel_center  <= RST_CHANNEL_CENTER;
         csr_ff.channel_full    <= RST_CHANNEL_FULL;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HEADER_VALUE:    csr_ff.header_value    <= csr_wdata[7:0];
            CSR_FOOTER_NORMAL:   csr_ff.footer_normal   <= csr_wdata[7:0];
            CSR_FOOTER_LOST:     csr_ff.footer_lost     <= csr_wdata[7:0];
            CSR_FOOTER_FAILSAFE: csr_ff.footer_failsafe <= csr_wdata[7:0];
            CSR_CHANNEL_CENTER:  csr_ff.channel_center  <= csr_wdata;
            CSR_CHANNEL_FULL:    csr_ff.channel_full    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The channel store is addressed with the next channel number, ch_in, so its registered
   // data belongs to the current channel by the time the sequencer needs it.
   sbusfd_unpack u_unpack (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr_ff),
      .byte_fire   (byte_fire),
      .data_byte   (req_data_byte),
      .frame_start (req_frame_start),
      .rd_index    (ch_in),
      .rd_data     (store_data),
      .frame_event (frame_event)
   );

   // Operands: rounding to nearest is folded in as (2|n|*4096 + |d|) / (2|d|).
   assign numer    = $signed({1'b0, store_data}) - $signed({1'b0, csr_ff.channel_center});
   assign denom    = $signed({1'b0, csr_ff.channel_full}) -
                     $signed({1'b0, csr_ff.channel_center});
   assign abs_num  = numer[CHANNEL_BITS] ? CHANNEL_BITS'(-numer) : numer[CHANNEL_BITS-1:0];
   assign abs_den  = denom[CHANNEL_BITS] ? CHANNEL_BITS'(-denom) : denom[CHANNEL_BITS-1:0];
   assign dividend = {1'b0, abs_num, 13'b0} + {14'b0, abs_den};
   assign divisor  = {abs_den, 1'b0};
   assign div_start = state_ff == S_START;

   sbusfd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .status   (div_status),
      .quotient (quotient)
   );

   // Sign, saturation and the zero-divisor case. The user must not change the divisor
   // while a frame is reported, which is not enforced; it is read from the registers.
   always_comb begin
      if (denom == '0) begin
         if (num_zero_ff) begin
            norm_value = 16'h0000;
         end else if (num_neg_ff) begin
            norm_value = 16'h8000;
         end else begin
            norm_value = 16'h7FFF;
         end
      end else if (!neg_ff) begin
         norm_value = (|quotient[DIVIDEND_W-1:15]) ? 16'h7FFF : {1'b0, quotient[14:0]};
      end else if (quotient > DIVIDEND_W'(32768)) begin
         norm_value = 16'h8000;
      end else begin
         norm_value = 16'(16'h0000 - quotient[15:0]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      lost_in      = lost_ff;
      fs_in        = fs_ff;
      raw_in       = raw_ff;
      neg_in       = neg_ff;
      num_neg_in   = num_neg_ff;
      num_zero_in  = num_zero_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      o_idx_in     = o_idx_ff;
      o_raw_in     = o_raw_ff;
      o_norm_in    = o_norm_ff;
      o_d1_in      = o_d1_ff;
      o_d2_in      = o_d2_ff;
      o_lost_in    = o_lost_ff;
      o_fs_in      = o_fs_ff;
      o_err_in     = o_err_ff;
      o_last_in    = o_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (frame_event.valid) begin
               if (frame_event.error_code != ERR_NONE) begin
                  // A single error transaction; the result register is free here.
                  rsp_valid_in = 1'b1;
                  o_idx_in     = '0;
                  o_raw_in     = '0;
                  o_norm_in    = '0;
                  o_d1_in      = 1'b0;
                  o_d2_in      = 1'b0;
                  o_lost_in    = 1'b1;
                  o_fs_in      = 1'b0;
                  o_err_in     = frame_event.error_code;
                  o_last_in    = 1'b1;
               end else begin
                  d1_in    = frame_event.digital_one;
                  d2_in    = frame_event.digital_two;
                  lost_in  = frame_event.lost_flag;
                  fs_in    = frame_event.failsafe_flag;
                  ch_in    = '0;
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            raw_in      = store_data;
            neg_in      = numer[CHANNEL_BITS] ^ denom[CHANNEL_BITS];
            num_neg_in  = numer[CHANNEL_BITS];
            num_zero_in = numer == '0;
            state_in    = S_DIV;
         end
         S_DIV: begin
            if (div_status.done && !div_status.busy) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_idx_in     = ch_ff;
               o_raw_in     = raw_ff;
               o_norm_in    = norm_value;
               o_d1_in      = d1_ff;
               o_d2_in      = d2_ff;
               o_lost_in    = lost_ff;
               o_fs_in      = fs_ff;
               o_err_in     = ERR_NONE;
               o_last_in    = ch_ff == CH_IDX_W'(CHANNEL_COUNT - 1);
               if (ch_ff == CH_IDX_W'(CHANNEL_COUNT - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  ch_in    = ch_ff + CH_IDX_W'(1);
                  state_in = S_START;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d1_ff       <= d1_in;
      d2_ff       <= d2_in;
      lost_ff     <= lost_in;
      fs_ff       <= fs_in;
      raw_ff      <= raw_in;
      neg_ff      <= neg_in;
      num_neg_ff  <= num_neg_in;
      num_zero_ff <= num_zero_in;
      o_idx_ff    <= o_idx_in;
      o_raw_ff    <= o_raw_in;
      o_norm_ff   <= o_norm_in;
      o_d1_ff     <= o_d1_in;
      o_d2_ff     <= o_d2_in;
      o_lost_ff   <= o_lost_in;
      o_fs_ff     <= o_fs_in;
      o_err_ff    <= o_err_in;
      o_last_ff   <= o_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_channel_index = o_idx_ff;
   assign rsp_raw_value     = o_raw_ff;
   assign rsp_normalized    = $signed(o_norm_ff);
   assign rsp_digital_one   = o_d1_ff;
   assign rsp_digital_two   = o_d2_ff;
   assign rsp_lost_flag     = o_lost_ff;
   assign rsp_failsafe_flag = o_fs_ff;
   assign rsp_error_code    = o_err_ff;
   assign rsp_last          = o_last_ff;

endmodule

// ----- sim/sbus_frame_decoder_tb.sv -----
module sbus_frame_decoder_tb import sbusfd_pkg::*; ();

   // One byte on the request side: the byte itself and the start-of-frame marker.
   typedef struct packed {
      logic [7:0] data;
      logic       start;
   } frame_byte_type;

   // One transaction on the result side, laid out like the rsp_ ports.
   typedef struct packed {
      logic [CH_IDX_W-1:0]     index;
      logic [CHANNEL_BITS-1:0] raw;
      logic signed [15:0]      scaled;
      logic                    digital_one;
      logic                    digital_two;
      logic                    lost;
      logic                    failsafe;
      logic [1:0]              err_code;
      logic                    last;
   } channel_result_type;

   // A payload level equal to RANDOM_PAYLOAD asks for random channel bits instead of a fixed level.
   localparam int RANDOM_PAYLOAD = -1;
   localparam int MAX_WAIT       = 14;
   // A good footer costs sixteen divisions plus the result side's stalls, and the
   // long hold-off below can sit on top of that, so the drain limit is generous.
   localparam int DRAIN_LIMIT    = 5000;
   // Once every expected result has arrived, a short pause is enough
   // for the decoder to be truly idle before its registers change.
   localparam int QUIET_CYCLES   = 50;
   localparam int HOLD_PHASE     = 5;
   localparam int HOLD_CYCLES    = 600;
   localparam int CYCLE_LIMIT    = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid       = 1'b0;
   logic                    req_stall;
   logic [7:0]              req_data_byte   = '0;
   logic                    req_frame_start = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall       = 1'b0;
   logic [CH_IDX_W-1:0]     rsp_channel_index;
   logic [CHANNEL_BITS-1:0] rsp_raw_value;
   logic signed [15:0]      rsp_normalized;
   logic                    rsp_digital_one;
   logic                    rsp_digital_two;
   logic                    rsp_lost_flag;
   logic                    rsp_failsafe_flag;
   logic [1:0]              rsp_error_code;
   logic                    rsp_last;
   logic                    csr_we          = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index       = '0;
   logic [CHANNEL_BITS-1:0] csr_wdata       = '0;

   sbus_frame_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_frame_start   (req_frame_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel_index (rsp_channel_index),
      .rsp_raw_value     (rsp_raw_value),
      .rsp_normalized    (rsp_normalized),
      .rsp_digital_one   (rsp_digital_one),
      .rsp_digital_two   (rsp_digital_two),
      .rsp_lost_flag     (rsp_lost_flag),
      .rsp_failsafe_flag (rsp_failsafe_flag),
      .rsp_error_code    (rsp_error_code),
      .rsp_last          (rsp_last),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Bytes waiting to be offered, and channel results waiting to be seen.
   frame_byte_type     pending_bytes[$];
   channel_result_type expected_results[$];

   int mismatch_count = 0;
   int cycle_count    = 0;

   // Test phase and idling mode. Both are changed only with nonblocking assignments at a
   // rising edge, so every clocked process sees the same value in a given cycle.
   int phase_no = 1;
   bit calm     = 1'b0;

   // Our own copy of the control registers, updated as each write is issued.
   csr_type reg_shadow;

   // Decoder state as we expect it to be after every accepted byte.
   logic [POS_W-1:0]        frame_pos;
   logic [18:0]             bit_acc;
   int                      acc_bits;
   logic [CHANNEL_BITS-1:0] channel_copy[CHANNEL_COUNT];
   logic [7:0]              flag_copy;
   logic                    header_ok;

   // (raw - center) / (full - center) in Q3.12, rounded half away from zero and then
   // saturated. With full equal to center the sign of the numerator alone decides.
   function automatic logic signed [15:0] scale_raw(input logic [CHANNEL_BITS-1:0] raw);
      longint num;
      longint den;
      longint an;
      longint ad;
      longint q;
      num = (longint'(raw) - longint'(reg_shadow.channel_center)) * 4096;
      den = longint'(reg_shadow.channel_full) - longint'(reg_shadow.channel_center);
      if (den == 0) begin
         if (num > 0) return 16'sh7FFF;
         if (num < 0) return -16'sh8000;
         return '0;
      end
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      q = (2 * an + ad) / (2 * ad);
      if ((num < 0) != (den < 0)) q = -q;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   // Advances the expected decoder state by one accepted byte and queues every result
   // that the byte causes.
   task automatic predict_byte(input logic [7:0] b, input logic start);
      int   first_ch;
      logic lost;
      logic fs;
      if (start) begin
         // A start marker inside an open frame aborts it before the new frame opens.
         if (frame_pos != POS_IDLE)
            expected_results.push_back(channel_result_type'{'0, '0, '0, 1'b0, 1'b0, 1'b1,
                                                            1'b0, ERR_SHORT, 1'b1});
         header_ok = (b == reg_shadow.header_value);
         bit_acc   = '0;
         acc_bits  = 0;
         flag_copy = '0;
         frame_pos = POS_FIRST;
      end else if (frame_pos != POS_IDLE && frame_pos <= POS_LAST_DATA) begin
         // Channel bits arrive LSB first; each full 11-bit group becomes the next channel.
         first_ch = ((int'(frame_pos) - 1) * 8 - acc_bits) / CHANNEL_BITS;
         bit_acc  = bit_acc | (19'(b) << acc_bits);
         acc_bits = acc_bits + 8;
         while (acc_bits >= CHANNEL_BITS) begin
            channel_copy[first_ch % CHANNEL_COUNT] = bit_acc[CHANNEL_BITS-1:0];
            first_ch = first_ch + 1;
            bit_acc  = bit_acc >> CHANNEL_BITS;
            acc_bits = acc_bits - CHANNEL_BITS;
         end
         frame_pos = frame_pos + 1'b1;
      end else if (frame_pos == POS_FLAG) begin
         flag_copy = b;
         frame_pos = frame_pos + 1'b1;
      end else if (frame_pos != POS_IDLE) begin
         // Footer byte. A bad header wins over a bad footer; either way the frame ends.
         frame_pos = POS_IDLE;
         if (!header_ok) begin
            expected_results.push_back(channel_result_type'{'0, '0, '0, 1'b0, 1'b0, 1'b1,
                                                            1'b0, ERR_HEADER, 1'b1});
         end else if (b != reg_shadow.footer_normal && b != reg_shadow.footer_lost &&
                      b != reg_shadow.footer_failsafe) begin
            expected_results.push_back(channel_result_type'{'0, '0, '0, 1'b0, 1'b0, 1'b1,
                                                            1'b0, ERR_FOOTER, 1'b1});
         end else begin
            lost = flag_copy[2];
            fs   = flag_copy[3];
            // The lost footer takes precedence when it equals the failsafe footer.
            if (b == reg_shadow.footer_lost) lost = 1'b1;
            else if (b == reg_shadow.footer_failsafe) fs = 1'b1;
            for (int k = 0; k < CHANNEL_COUNT; k++)
               expected_results.push_back(channel_result_type'{
                  CH_IDX_W'(k), channel_copy[k], scale_raw(channel_copy[k]),
                  flag_copy[0], flag_copy[1], lost, fs, ERR_NONE,
                  k == CHANNEL_COUNT - 1});
         end
      end
      // A byte with no start marker while no frame is open leaves everything untouched.
   endtask

   // Sender. An accepted byte is fed to the predictor at the edge where it is taken.
   // After each byte a random gap of up to MAX_WAIT is drawn, except in calm phases.
   int send_wait = 0;

   always @(posedge clock) begin : drive_bytes
      frame_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) predict_byte(req_data_byte, req_frame_start);
         if (send_wait != 0) begin
            send_wait <= send_wait - 1;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            nxt = pending_bytes.pop_front();
            req_data_byte   <= nxt.data;
            req_frame_start <= nxt.start;
            req_valid       <= 1'b1;
            send_wait       <= calm ? 0 : $urandom_range(0, MAX_WAIT);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Long hold-off on the result side. Once in the pressure phase, the first result
   // that shows up starts a long hold on results while the sender keeps offering the
   // next frame, so the decoder backs up and stalls its input.
   logic hold_off  = 1'b0;
   int   hold_left = 0;
   bit   hold_used = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         hold_off  <= 1'b0;
         hold_left <= 0;
         hold_used <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         if (hold_left == 1) hold_off <= 1'b0;
      end else if (!hold_used && phase_no == HOLD_PHASE && rsp_valid) begin
         hold_left <= HOLD_CYCLES;
         hold_off  <= 1'b1;
         hold_used <= 1'b1;
      end
   end

   function automatic void match_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Receiver. Every accepted result transaction is compared with the oldest expectation.
   // The stall counter runs freely so that stalls land on every phase of the decoder.
   int rsp_wait = 0;

   always @(posedge clock) begin : watch_results
      channel_result_type want;
      int                 wait_n;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait  <= 0;
      end else begin
         wait_n = rsp_wait;
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result transaction for channel %0d", rsp_channel_index);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               match_field("channel_index", want.index, rsp_channel_index);
               match_field("raw_value", want.raw, rsp_raw_value);
               match_field("normalized", want.scaled, rsp_normalized);
               match_field("digital_one", want.digital_one, rsp_digital_one);
               match_field("digital_two", want.digital_two, rsp_digital_two);
               match_field("lost_flag", want.lost, rsp_lost_flag);
               match_field("failsafe_flag", want.failsafe, rsp_failsafe_flag);
               match_field("error_code", want.err_code, rsp_error_code);
               match_field("last", want.last, rsp_last);
            end
            wait_n = calm ? 0 : $urandom_range(0, MAX_WAIT);
         end else if (wait_n != 0) begin
            wait_n = wait_n - 1;
         end
         rsp_wait  <= wait_n;
         rsp_stall <= hold_off || wait_n != 0;
      end
   end

   // Watchdog: a hung decoder ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Queues the first 'keep' bytes of a frame. The 22 payload bytes carry either random
   // bits or sixteen copies of one 11-bit level, packed LSB first.
   task automatic queue_frame(input logic [7:0] head, input logic [7:0] flags,
                              input logic [7:0] foot, input int keep, input int level);
      logic [CHANNEL_COUNT*CHANNEL_BITS-1:0] packed_levels;
      logic [7:0]                            b;
      packed_levels = {CHANNEL_COUNT{11'(level)}};
      for (int i = 0; i < keep; i++) begin
         if (i == 0) b = head;
         else if (i == FRAME_BYTES - 2) b = flags;
         else if (i == FRAME_BYTES - 1) b = foot;
         else if (level == RANDOM_PAYLOAD) b = 8'($urandom);
         else b = packed_levels[8*(i-1) +: 8];
         pending_bytes.push_back(frame_byte_type'{b, i == 0});
      end
   endtask

   // Mostly well-formed frames with random content, sprinkled with stray bytes, frames
   // cut short, wrong headers and wrong footers. The last frame always closes cleanly.
   task automatic queue_random_traffic(input int byte_budget);
      int         goal;
      int         pick;
      logic [7:0] head;
      logic [7:0] foot;
      goal = pending_bytes.size() + byte_budget;
      while (pending_bytes.size() < goal) begin
         pick = $urandom_range(0, 15);
         head = ($urandom_range(0, 7) == 0) ? 8'($urandom) : reg_shadow.header_value;
         case ($urandom_range(0, 5))
            0: foot = reg_shadow.footer_lost;
            1: foot = reg_shadow.footer_failsafe;
            2: foot = 8'($urandom);
            default: foot = reg_shadow.footer_normal;
         endcase
         if (pick == 0) begin
            repeat ($urandom_range(1, 3))
               pending_bytes.push_back(frame_byte_type'{8'($urandom), 1'b0});
         end else if (pick == 1) begin
            queue_frame(head, 8'($urandom), foot, $urandom_range(1, FRAME_BYTES - 1),
                        RANDOM_PAYLOAD);
         end else begin
            queue_frame(head, 8'($urandom), foot, FRAME_BYTES, RANDOM_PAYLOAD);
         end
      end
      queue_frame(reg_shadow.header_value, 8'($urandom), reg_shadow.footer_normal,
                  FRAME_BYTES, RANDOM_PAYLOAD);
   endtask

   // Waits until every byte is taken and every expected result has arrived or the drain
   // limit runs out, then lets the decoder settle so the registers can be rewritten safely.
   task automatic wait_for_quiet();
      int waited;
      while (pending_bytes.size() != 0 || req_valid) @(negedge clock);
      waited = 0;
      while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CHANNEL_BITS-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_HEADER_VALUE:    reg_shadow.header_value    = value[7:0];
         CSR_FOOTER_NORMAL:   reg_shadow.footer_normal   = value[7:0];
         CSR_FOOTER_LOST:     reg_shadow.footer_lost     = value[7:0];
         CSR_FOOTER_FAILSAFE: reg_shadow.footer_failsafe = value[7:0];
         CSR_CHANNEL_CENTER:  reg_shadow.channel_center  = value;
         CSR_CHANNEL_FULL:    reg_shadow.channel_full    = value;
         default: ;
      endcase
   endtask

   // Rewrites all six registers and enters the next phase. The byte registers get random
   // bits above bit 7, which the decoder must drop.
   task automatic program_regs(input logic [7:0] head, input logic [7:0] fnorm,
                               input logic [7:0] flost, input logic [7:0] ffail,
                               input logic [CHANNEL_BITS-1:0] center,
                               input logic [CHANNEL_BITS-1:0] full,
                               input int phase, input bit quiet);
      write_reg(CSR_HEADER_VALUE, {3'($urandom), head});
      write_reg(CSR_FOOTER_NORMAL, {3'($urandom), fnorm});
      write_reg(CSR_FOOTER_LOST, {3'($urandom), flost});
      write_reg(CSR_FOOTER_FAILSAFE, {3'($urandom), ffail});
      write_reg(CSR_CHANNEL_CENTER, center);
      write_reg(CSR_CHANNEL_FULL, full);
      @(posedge clock);
      csr_we   <= 1'b0;
      phase_no <= phase;
      calm     <= quiet;
      @(negedge clock);
   endtask

   initial begin
      reg_shadow = '{RST_HEADER_VALUE, RST_FOOTER_NORMAL, RST_FOOTER_LOST,
                     RST_FOOTER_FAILSAFE, RST_CHANNEL_CENTER, RST_CHANNEL_FULL};
      frame_pos = POS_IDLE;
      bit_acc   = '0;
      acc_bits  = 0;
      flag_copy = '0;
      header_ok = 1'b0;
      foreach (channel_copy[k]) channel_copy[k] = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Phase 1 runs on the reset values of the registers: stray bytes before any
      // frame, zero channels with the lost footer, the failsafe footer, a bad footer,
      // a bad header together with a bad footer, frames cut short right after the
      // header and just before the footer, and channels exactly at the center.
      pending_bytes.push_back(frame_byte_type'{8'hFF, 1'b0});
      pending_bytes.push_back(frame_byte_type'{8'h00, 1'b0});
      queue_frame(8'h0F, 8'h0F, 8'h04, FRAME_BYTES, 0);
      queue_frame(8'h0F, 8'h03, 8'h08, FRAME_BYTES, RANDOM_PAYLOAD);
      queue_frame(8'h0F, 8'h00, 8'hFF, FRAME_BYTES, RANDOM_PAYLOAD);
      queue_frame(8'hF0, 8'h00, 8'hFF, FRAME_BYTES, RANDOM_PAYLOAD);
      queue_frame(8'h0F, 8'h00, 8'h00, 1, RANDOM_PAYLOAD);
      queue_frame(8'h0F, 8'hF4, 8'h00, FRAME_BYTES - 1, RANDOM_PAYLOAD);
      queue_frame(8'h0F, 8'h04, 8'h00, FRAME_BYTES, 1024);
      pending_bytes.push_back(frame_byte_type'{8'hA5, 1'b0});
      wait_for_quiet();

      // Extreme scale with the full input range and the header and normal footer at their limits.
      program_regs(8'h00, 8'hFF, 8'h80, 8'h01, 11'd0, 11'd2047, 2, 1'b1);
      queue_random_traffic(0);
      wait_for_quiet();

      // Inverted scale, and a lost footer that equals the normal footer.
      program_regs(8'hFF, 8'h55, 8'h55, 8'hAA, 11'd2047, 11'd0, 3, 1'b0);
      queue_random_traffic(0);
      wait_for_quiet();

      // Zero divisor, with channels above, below and exactly at the center, and a lost
      // footer that equals the failsafe footer.
      program_regs(8'hA5, 8'h00, 8'h33, 8'h33, 11'd1000, 11'd1000, 4, 1'b0);
      queue_frame(8'hA5, 8'hFF, 8'h33, FRAME_BYTES, 1000);
      queue_frame(8'hA5, 8'h00, 8'h00, FRAME_BYTES, 0);
      queue_frame(8'hA5, 8'h02, 8'h00, FRAME_BYTES, 2047);
      wait_for_quiet();

      // A divisor of one saturates almost every channel; the long hold-off happens here
      // while the second frame is already being offered.
      program_regs(8'h0F, 8'h00, 8'h04, 8'h08, 11'd1024, 11'd1025, HOLD_PHASE, 1'b0);
      queue_frame(8'h0F, 8'($urandom), 8'h00, FRAME_BYTES, RANDOM_PAYLOAD);
      queue_frame(8'h0F, 8'($urandom), 8'h00, FRAME_BYTES, RANDOM_PAYLOAD);
      wait_for_quiet();

      // Fully random register settings.
      program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   11'($urandom), 11'($urandom), 6, 1'b0);
      queue_random_traffic(0);
      wait_for_quiet();

      if (expected_results.size() != 0) begin
         $error("%0d expected result transactions never arrived", expected_results.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/sbusfd_pkg.sv
rtl/sbusfd_unpack.sv
rtl/sbusfd_divider.sv
rtl/sbus_frame_decoder.sv
sim/sbus_frame_decoder_tb.sv
